// ===== rtl/core/fds_pkg.sv =====
`default_nettype none

package fds_pkg;

  localparam logic [3:0] MAX_DIGITS = 4'd9;
  localparam logic [30:0] INT_SAT = 31'h7FFF_FFFF;

  // 10^0 .. 10^9, all below 2^30
  localparam logic [29:0] POW10 [10] = '{
    30'd1, 30'd10, 30'd100, 30'd1000, 30'd10000, 30'd100000,
    30'd1000000, 30'd10000000, 30'd100000000, 30'd1000000000
  };

  // after decode: magnitude as Q31.64 split in hi and lo
  typedef struct packed {
    logic        neg;
    logic        ovf;
    logic        zero;
    logic [30:0] hi;
    logic [63:0] lo;
    logic [29:0] p;
  } dec_t;

  // after the two partial products of lo times 10^d
  typedef struct packed {
    logic        neg;
    logic        ovf;
    logic        zero;
    logic [30:0] hi;
    logic [61:0] t0;
    logic [61:0] t1;
    logic [29:0] p;
  } mul_t;

  // after rounding of the scaled fraction
  typedef struct packed {
    logic        neg;
    logic        ovf;
    logic        zero;
    logic [30:0] hi;
    logic [30:0] q;
    logic [29:0] p;
  } rnd_t;

  typedef struct packed {
    logic        negative;
    logic [30:0] integer_part;
    logic [29:0] fraction_digits;
    logic        overflow;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/fds_decode.sv =====
`default_nettype none

module fds_decode import fds_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] value_bits,
  input  wire logic [3:0]  digits,
  output logic             out_valid,
  input  wire logic        out_ready,
  output dec_t             out_data
);

  logic        sign;
  logic [7:0]  expo;
  logic [22:0] mant;
  logic [3:0]  d_sat;
  logic [6:0]  sh;
  logic [94:0] wide;
  dec_t        data_next;

  assign sign = value_bits[31];
  assign expo = value_bits[30:23];
  assign mant = value_bits[22:0];
  assign d_sat = (digits > MAX_DIGITS) ? MAX_DIGITS : digits;
  // shift is 1..71 for the exponents that reach the fixed-point range
  assign sh = 7'(expo - 8'd86);
  assign wide = 95'({1'b1, mant}) << sh;

  always_comb begin
    data_next.ovf  = (expo == 8'hFF) || (expo >= 8'd158);
    data_next.zero = (expo < 8'd87);
    if (expo == 8'hFF) begin
      data_next.neg = (mant == 23'd0) ? sign : 1'b0;
    end else begin
      data_next.neg = sign && ((expo != 8'd0) || (mant != 23'd0));
    end
    data_next.hi = wide[94:64];
    data_next.lo = wide[63:0];
    data_next.p  = POW10[d_sat];
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fds_mult.sv =====
`default_nettype none

module fds_mult import fds_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire dec_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output mul_t      out_data
);

  mul_t data_next;

  // two 32x30 partial products of the fraction word
  always_comb begin
    data_next.neg  = in_data.neg;
    data_next.ovf  = in_data.ovf;
    data_next.zero = in_data.zero;
    data_next.hi   = in_data.hi;
    data_next.p    = in_data.p;
    data_next.t0   = 62'(in_data.lo[31:0]) * 62'(in_data.p);
    data_next.t1   = 62'(in_data.lo[63:32]) * 62'(in_data.p);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fds_round.sv =====
`default_nettype none

module fds_round import fds_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire mul_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output rnd_t      out_data
);

  logic [33:0] mid;
  rnd_t        data_next;

  // add half an lsb at bit 63 of the product, keep bits 64 and up
  assign mid = 34'(in_data.t0[61:32]) + 34'(in_data.t1[31:0]) + 34'h8000_0000;

  always_comb begin
    data_next.neg  = in_data.neg;
    data_next.ovf  = in_data.ovf;
    data_next.zero = in_data.zero;
    data_next.hi   = in_data.hi;
    data_next.p    = in_data.p;
    data_next.q    = 31'(in_data.t1[61:32]) + 31'(mid[33:32]);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fds_final.sv =====
`default_nettype none

module fds_final import fds_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire rnd_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_data
);

  logic        carry;
  logic [31:0] hi_sum;
  res_t        data_next;

  // fraction rounded up to 10^d carries into the integer part
  assign carry  = (in_data.q >= 31'(in_data.p));
  assign hi_sum = 32'(in_data.hi) + 32'(carry);

  always_comb begin
    data_next.negative = in_data.neg;
    if (in_data.ovf || hi_sum[31]) begin
      data_next.integer_part    = INT_SAT;
      data_next.fraction_digits = 30'd0;
      data_next.overflow        = 1'b1;
    end else if (in_data.zero) begin
      data_next.integer_part    = 31'd0;
      data_next.fraction_digits = 30'd0;
      data_next.overflow        = 1'b0;
    end else begin
      data_next.integer_part    = hi_sum[30:0];
      data_next.fraction_digits = carry ? 30'd0 : in_data.q[29:0];
      data_next.overflow        = 1'b0;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/float_to_decimal_split_core.sv =====
// channel | handshake           | payload
// input   | in_valid, in_ready   | value_bits[31:0], digits[3:0]
// output  | out_valid, out_ready | negative, integer_part[30:0], fraction_digits[29:0], overflow
//
// one transaction per cycle sustained while out_ready is high; every stage is registered
// stages: decode and shift, 32x30 partial products, rounding add, carry and saturation
// rst (synchronous) clears the stage valid bits; payload registers are not reset
// a stall on the output holds each full stage in place, bubbles are still filled
`default_nettype none

module float_to_decimal_split_core import fds_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] value_bits,
  input  wire logic [3:0]  digits,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             negative,
  output logic [30:0]      integer_part,
  output logic [29:0]      fraction_digits,
  output logic             overflow
);

  dec_t dec_data;
  mul_t mul_data;
  rnd_t rnd_data;
  res_t res_data;
  logic dec_valid, dec_ready;
  logic mul_valid, mul_ready;
  logic rnd_valid, rnd_ready;

  fds_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value_bits (value_bits),
    .digits     (digits),
    .out_valid  (dec_valid),
    .out_ready  (dec_ready),
    .out_data   (dec_data)
  );

  fds_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_data   (dec_data),
    .out_valid (mul_valid),
    .out_ready (mul_ready),
    .out_data  (mul_data)
  );

  fds_round u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_valid),
    .in_ready  (mul_ready),
    .in_data   (mul_data),
    .out_valid (rnd_valid),
    .out_ready (rnd_ready),
    .out_data  (rnd_data)
  );

  fds_final u_final (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rnd_valid),
    .in_ready  (rnd_ready),
    .in_data   (rnd_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (res_data)
  );

  assign negative        = res_data.negative;
  assign integer_part    = res_data.integer_part;
  assign fraction_digits = res_data.fraction_digits;
  assign overflow        = res_data.overflow;

  a_ovf_saturates: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> (integer_part == INT_SAT) && (fraction_digits == 30'd0))
    else $error("overflow without saturated result");

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fraction_digits <= 30'd999999999))
    else $error("fraction digits out of range");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output is free");

  a_stage_fill: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> dec_valid && mul_valid && rnd_valid)
    else $error("input stalled with a bubble in the pipeline");

endmodule

`default_nettype wire
